// ===== hdl/wbsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbsd_pkg
// Shared widths, reset values, register indexes and command codes of the
// white blob steering detector.
// ----------------------------------------------------------------------------
package wbsd_pkg;

  // Pixel and configuration field widths
  localparam int CHAN_W   = 8;
  localparam int COL_W    = 12;
  localparam int THR_W    = 8;
  localparam int SIDE_W   = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;

  // Accumulator widths
  localparam int CNT_W    = 25;
  localparam int SUM_W    = 38;
  localparam int OFF_W    = COL_W + 2;

  // Default clamp on width and height
  localparam int MAX_IMAGE_SIDE_DEF = 4096;

  // Register reset values
  localparam logic [THR_W-1:0]  THR_RST    = 8'd250;
  localparam logic [SIDE_W-1:0] WIDTH_RST  = 13'd800;
  localparam logic [SIDE_W-1:0] HEIGHT_RST = 13'd800;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_WIDTH     = 2'd1,
    CFG_HEIGHT    = 2'd2
  } cfg_idx_t;

  // Turn command codes
  localparam logic signed [1:0] TURN_LEFT     = 2'sb01;
  localparam logic signed [1:0] TURN_STRAIGHT = 2'sb00;
  localparam logic signed [1:0] TURN_RIGHT    = 2'sb11;

endpackage

// ===== hdl/wbsd_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbsd channels
// Valid/ready channels for pixels, drive commands and register writes.
// ----------------------------------------------------------------------------
interface wbsd_in_if;
  logic                         valid;
  logic                         ready;
  logic [wbsd_pkg::CHAN_W-1:0]  red;
  logic [wbsd_pkg::CHAN_W-1:0]  green;
  logic [wbsd_pkg::CHAN_W-1:0]  blue;
  logic [wbsd_pkg::COL_W-1:0]   column;
  logic                         end_of_frame;

  modport source (output valid, red, green, blue, column, end_of_frame, input ready);
  modport sink   (input valid, red, green, blue, column, end_of_frame, output ready);
endinterface

interface wbsd_out_if;
  logic              valid;
  logic              ready;
  logic              forward;
  logic signed [1:0] turn;
  logic              ball_seen;
  logic              too_close;

  modport source (output valid, forward, turn, ball_seen, too_close, input ready);
  modport sink   (input valid, forward, turn, ball_seen, too_close, output ready);
endinterface

interface wbsd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wbsd_pkg::CFG_IDX_W-1:0] index;
  logic [wbsd_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/white_blob_steering_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// white_blob_steering_detector
// Counts white pixels of a frame and their byte offsets, and at the end of
// the frame issues a drive command when it differs from the last one.
// ----------------------------------------------------------------------------
// Takes one pixel per clock. A pixel passes through four registered stages:
// input register, accumulate, multiply (W*count, W*H, 20*count) and decide;
// the command lands in the output register when the decide stage issues it.
// The only stall comes from the decide stage: when a frame's command
// must be issued while the output register still holds an untaken command,
// the whole pipeline and in_if.ready hold until out_if.ready frees it.
// Register writes are always taken (cfg_if.ready is tied high) and are meant
// for idle periods; width and height are clamped to MAX_IMAGE_SIDE.
module white_blob_steering_detector #(
  parameter int MAX_IMAGE_SIDE = wbsd_pkg::MAX_IMAGE_SIDE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  wbsd_in_if.sink     in_if,
  wbsd_out_if.source  out_if,
  wbsd_cfg_if.sink    cfg_if
);

  localparam int CW  = wbsd_pkg::CNT_W;
  localparam int SW  = wbsd_pkg::SUM_W;
  localparam int XW  = wbsd_pkg::SIDE_W;
  localparam int WCW = XW + CW;       // W * count
  localparam int WHW = 2 * XW;        // W * H
  localparam int C20W = CW + 5;       // 20 * count

  // Configuration registers
  logic [wbsd_pkg::THR_W-1:0] thr_r;
  logic [XW-1:0]              width_r;
  logic [XW-1:0]              height_r;

  // Input stage
  logic                          p_v_r;
  logic [wbsd_pkg::CHAN_W-1:0]   p_red_r, p_green_r, p_blue_r;
  logic [wbsd_pkg::COL_W-1:0]    p_col_r;
  logic                          p_eof_r;

  // Accumulators and frame totals
  logic [CW-1:0] acc_cnt_r;
  logic [SW-1:0] acc_sum_r;
  logic          fr_v_r;
  logic [CW-1:0] fr_cnt_r;
  logic [SW-1:0] fr_sum_r;

  // Multiply stage
  logic            m_v_r;
  logic            m_seen_r;
  logic [SW-1:0]   m_sum_r;
  logic [WCW-1:0]  m_wc_r;
  logic [WHW-1:0]  m_wh_r;
  logic [C20W-1:0] m_c20_r;

  // Command state and output register
  logic              last_fwd_r;
  logic signed [1:0] last_turn_r;
  logic              o_v_r;
  logic              o_fwd_r;
  logic signed [1:0] o_turn_r;
  logic              o_seen_r;
  logic              o_close_r;

  logic              adv;
  logic              white;
  logic [CW-1:0]     cnt_nxt;
  logic [SW:0]       sum_add;
  logic [SW-1:0]     sum_nxt;
  logic [wbsd_pkg::OFF_W-1:0] off;
  logic [XW-1:0]     w_cl, h_cl;
  logic [WCW:0]      wc2;
  logic              lt1, lt2, close, fwd, emit;
  logic signed [1:0] turn;

  // Register writes
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= wbsd_pkg::THR_RST;
      width_r  <= wbsd_pkg::WIDTH_RST;
      height_r <= wbsd_pkg::HEIGHT_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        wbsd_pkg::CFG_THRESHOLD: thr_r    <= cfg_if.data[wbsd_pkg::THR_W-1:0];
        wbsd_pkg::CFG_WIDTH:     width_r  <= cfg_if.data;
        wbsd_pkg::CFG_HEIGHT:    height_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // Clamp sides to the configured maximum
  assign w_cl = (32'(width_r)  > MAX_IMAGE_SIDE) ? XW'(MAX_IMAGE_SIDE) : width_r;
  assign h_cl = (32'(height_r) > MAX_IMAGE_SIDE) ? XW'(MAX_IMAGE_SIDE) : height_r;

  // Decide stage: turn and forward from the frame totals
  assign wc2   = {m_wc_r, 1'b0};
  assign lt1   = m_sum_r < m_wc_r;
  assign lt2   = {{(WCW+1-SW){1'b0}}, m_sum_r} < wc2;
  assign close = m_c20_r > {{(C20W-WHW){1'b0}}, m_wh_r};
  assign fwd   = m_seen_r && !close;

  always_comb begin
    if (!m_seen_r) begin
      turn = wbsd_pkg::TURN_STRAIGHT;
    end else if (lt1) begin
      turn = wbsd_pkg::TURN_LEFT;
    end else if (lt2) begin
      turn = wbsd_pkg::TURN_STRAIGHT;
    end else begin
      turn = wbsd_pkg::TURN_RIGHT;
    end
  end

  assign emit = m_v_r && ((fwd != last_fwd_r) || (turn != last_turn_r));

  // Hold the pipeline only when a new command meets a full output register
  assign adv         = !(emit && o_v_r && !out_if.ready);
  assign in_if.ready = adv;

  // Accumulate stage: white test and saturating sums
  assign white = (p_red_r > thr_r) && (p_green_r > thr_r) && (p_blue_r > thr_r);
  assign off   = {2'b00, p_col_r} + {1'b0, p_col_r, 1'b0};
  assign sum_add = {1'b0, acc_sum_r} + (SW+1)'(off);

  always_comb begin
    cnt_nxt = acc_cnt_r;
    sum_nxt = acc_sum_r;
    if (white) begin
      if (acc_cnt_r != {CW{1'b1}}) begin
        cnt_nxt = acc_cnt_r + CW'(1);
      end
      sum_nxt = sum_add[SW] ? {SW{1'b1}} : sum_add[SW-1:0];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r       <= 1'b0;
      fr_v_r      <= 1'b0;
      m_v_r       <= 1'b0;
      acc_cnt_r   <= '0;
      acc_sum_r   <= '0;
      last_fwd_r  <= 1'b0;
      last_turn_r <= wbsd_pkg::TURN_STRAIGHT;
      o_v_r       <= 1'b0;
    end else begin
      if (adv) begin
        p_v_r  <= in_if.valid;
        fr_v_r <= p_v_r && p_eof_r;
        m_v_r  <= fr_v_r;
        if (p_v_r) begin
          acc_cnt_r <= p_eof_r ? '0 : cnt_nxt;
          acc_sum_r <= p_eof_r ? '0 : sum_nxt;
        end
        if (emit) begin
          last_fwd_r  <= fwd;
          last_turn_r <= turn;
        end
      end
      // Output valid: set on a new command, drop once taken
      if (adv && emit) begin
        o_v_r <= 1'b1;
      end else if (out_if.ready) begin
        o_v_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      p_red_r   <= in_if.red;
      p_green_r <= in_if.green;
      p_blue_r  <= in_if.blue;
      p_col_r   <= in_if.column;
      p_eof_r   <= in_if.end_of_frame;
      fr_cnt_r  <= cnt_nxt;
      fr_sum_r  <= sum_nxt;
      m_seen_r  <= fr_cnt_r != '0;
      m_sum_r   <= fr_sum_r;
      m_wc_r    <= WCW'(w_cl) * WCW'(fr_cnt_r);
      m_wh_r    <= WHW'(w_cl) * WHW'(h_cl);
      m_c20_r   <= {fr_cnt_r, 4'b0000} + {2'b00, fr_cnt_r, 2'b00} + C20W'(0);
      if (emit) begin
        o_fwd_r   <= fwd;
        o_turn_r  <= turn;
        o_seen_r  <= m_seen_r;
        o_close_r <= close;
      end
    end
  end

  assign out_if.valid     = o_v_r;
  assign out_if.forward   = o_fwd_r;
  assign out_if.turn      = o_turn_r;
  assign out_if.ball_seen = o_seen_r;
  assign out_if.too_close = o_close_r;

endmodule
